// ----- design/srsf_pkg.sv -----
// Shared types and constants for the short run slot filter.
// Depends on nothing; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package srsf_pkg;

    // Fixed field widths of the channel words.
    localparam int unsigned MAX_SLOTS    = 64;
    localparam int unsigned RUN_W        = 7;
    localparam int unsigned COUNT_W      = 6;
    localparam int unsigned SLOT_COUNT_DEFAULT = 64;

    typedef logic [MAX_SLOTS-1:0] t_mask;
    typedef logic [RUN_W-1:0]     t_run;
    typedef logic [COUNT_W-1:0]   t_count;

    // Partial scan state that travels down the chain of cells.
    typedef struct packed {
        t_mask  slot_mask;
        t_run   min_run;
        t_run   run_len;
        t_mask  run_bits;
        t_mask  kept;
        t_count runs;
    } t_token;

endpackage

`default_nettype wire

// ----- design/srsf_if.sv -----
// Valid/ready channel interfaces for the short run slot filter.
// Depends on srsf_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface srsf_in_if;
    logic                 valid;
    logic                 ready;
    srsf_pkg::t_mask      slot_mask;
    srsf_pkg::t_run       min_run;

    modport source (output valid, output slot_mask, output min_run, input ready);
    modport sink   (input valid, input slot_mask, input min_run, output ready);
endinterface

interface srsf_out_if;
    logic                 valid;
    logic                 ready;
    srsf_pkg::t_mask      kept_mask;
    srsf_pkg::t_count     fragment_count;

    modport source (output valid, output kept_mask, output fragment_count, input ready);
    modport sink   (input valid, input kept_mask, input fragment_count, output ready);
endinterface

`default_nettype wire

// ----- design/srsf_cell.sv -----
// One cell of the scan chain: examines a single slot and registers the token.
// Depends on srsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srsf_cell #(
    parameter int unsigned SLOT_INDEX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire srsf_pkg::t_token i_tok,
    output logic                  o_valid,
    output srsf_pkg::t_token      o_tok
);

    logic             r_valid;
    srsf_pkg::t_token r_tok;
    srsf_pkg::t_token n_tok;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.slot_mask[SLOT_INDEX]) begin
            // Slot present: extend the current run, counting it when it opens here.
            if (i_tok.run_len == '0) begin
                n_tok.runs = i_tok.runs + srsf_pkg::t_count'(1);
            end
            n_tok.run_len              = i_tok.run_len + srsf_pkg::t_run'(1);
            n_tok.run_bits[SLOT_INDEX] = 1'b1;
        end else begin
            // Gap: the open run closes, and is kept if it is long enough.
            if ((i_tok.run_len != '0) && (i_tok.run_len >= i_tok.min_run)) begin
                n_tok.kept = i_tok.kept | i_tok.run_bits;
            end
            n_tok.run_bits = '0;
            n_tok.run_len  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

`default_nettype wire

// ----- design/srsf_tail.sv -----
// Output stage: closes a run that reaches the top slot and holds the result word.
// Depends on srsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srsf_tail (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire srsf_pkg::t_token i_tok,
    output logic                  o_valid,
    output srsf_pkg::t_mask       o_kept_mask,
    output srsf_pkg::t_count      o_fragment_count
);

    logic              r_valid;
    srsf_pkg::t_mask   r_kept;
    srsf_pkg::t_count  r_count;
    srsf_pkg::t_mask   n_kept;

    always_comb begin
        n_kept = i_tok.kept;
        if ((i_tok.run_len != '0) && (i_tok.run_len >= i_tok.min_run)) begin
            n_kept = i_tok.kept | i_tok.run_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kept  <= n_kept;
            r_count <= i_tok.runs;
        end
    end

    assign o_valid          = r_valid;
    assign o_kept_mask      = r_kept;
    assign o_fragment_count = r_count;

endmodule

`default_nettype wire

// ----- design/short_run_slot_filter_top.sv -----
// Top level of the short run slot filter: a chain of slot cells and an output stage.
// Depends on srsf_pkg, srsf_if, srsf_cell and srsf_tail.
//
//   Channel   Direction  Contents of one word
//   i_in      in         slot_mask[63:0], min_run[6:0]
//   o_out     out        kept_mask[63:0], fragment_count[5:0]
//
// One word enters per cycle while the chain is not stalled; each result passes
// through the chain of SLOT_COUNT cells, one per slot, and then the output
// register. Reset clears every valid flag of the chain.
// When the output word is held and not taken, the whole chain stalls together,
// so i_in.ready follows o_out.ready whenever the output register is full.
`timescale 1ns / 1ps
`default_nettype none

module short_run_slot_filter_top #(
    parameter int unsigned SLOT_COUNT = srsf_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    srsf_in_if.sink   i_in,
    srsf_out_if.source o_out
);

    // Slots at or above SLOT_COUNT are dropped before the scan starts.
    localparam srsf_pkg::t_mask SlotValid =
        (SLOT_COUNT >= srsf_pkg::MAX_SLOTS) ? '1 :
        ((srsf_pkg::t_mask'(1) << SLOT_COUNT) - srsf_pkg::t_mask'(1));

    logic             w_en;
    logic             w_valid [SLOT_COUNT+1];
    srsf_pkg::t_token w_tok   [SLOT_COUNT+1];

    // The chain moves as a whole whenever the output register can take a word.
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // The first cell sees a fresh token: no run open, nothing kept, no runs counted.
    assign w_valid[0] = i_in.valid;
    assign w_tok[0]   = '{
        slot_mask: i_in.slot_mask & SlotValid,
        min_run:   i_in.min_run,
        run_len:   '0,
        run_bits:  '0,
        kept:      '0,
        runs:      '0
    };

    // Cell k scans slot k and registers its token for cell k+1.
    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
        srsf_cell #(
            .SLOT_INDEX(k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_tok   (w_tok[k]),
            .o_valid (w_valid[k+1]),
            .o_tok   (w_tok[k+1])
        );
    end

    // The output stage closes a run that ends at the top slot.
    srsf_tail u_tail (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_valid          (w_valid[SLOT_COUNT]),
        .i_tok            (w_tok[SLOT_COUNT]),
        .o_valid          (o_out.valid),
        .o_kept_mask      (o_out.kept_mask),
        .o_fragment_count (o_out.fragment_count)
    );

endmodule

`default_nettype wire

// ----- design/srsf_checker.sv -----
// Port-level checks for the short run slot filter, bound to the top level.
// Depends on srsf_pkg and on the ports of short_run_slot_filter_top.
`timescale 1ns / 1ps
`default_nettype none

module srsf_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire srsf_pkg::t_mask  i_kept_mask,
    input wire srsf_pkg::t_count i_fragment_count
);

    // Reset empties the output register on the next edge.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    // At most half of the slots can start a run.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_fragment_count <= srsf_pkg::t_count'(srsf_pkg::MAX_SLOTS / 2)))
        else $error("fragment count above its bound");

    // A kept slot lies in some run, so the count cannot be zero.
    a_kept_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kept_mask != '0)) |-> (i_fragment_count != '0))
        else $error("slots kept with no runs counted");

    // A held output word keeps its payload.
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_kept_mask) && $stable(i_fragment_count)))
        else $error("output word changed while stalled");

endmodule

bind short_run_slot_filter_top srsf_checker u_srsf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_kept_mask      (o_out.kept_mask),
    .i_fragment_count (o_out.fragment_count)
);

`default_nettype wire
